@@ hw/rtl/scpa_pkg.sv @@
// ----------------------------------------------------------------------------
// scpa_pkg
// Shared types and constants of the size-class pool allocator.
// ----------------------------------------------------------------------------
package scpa_pkg;

  localparam int CLASS_COUNT       = 16;
  localparam int GROUP_BYTES       = 16;
  localparam int CELLS_PER_POOL    = 64;
  localparam int POOL_SLOTS        = 16;
  localparam int HEADER_BYTES      = 8;
  localparam int MIN_PAYLOAD_BYTES = 8;

  localparam int TOTAL_CELLS = CELLS_PER_POOL * POOL_SLOTS;
  localparam int CELL_W      = 11;   // holds TOTAL_CELLS as the empty marker
  localparam int HANDLE_W    = 10;
  localparam int CLS_W       = 4;
  localparam int SLOT_W      = 4;
  localparam int POOLREF_W   = 5;    // holds POOL_SLOTS as the empty marker
  localparam int CNT_W       = 11;
  localparam int OFS_W       = 6;

  localparam logic [CELL_W-1:0]    CELL_NONE = CELL_W'(TOTAL_CELLS);
  localparam logic [POOLREF_W-1:0] POOL_NONE = POOLREF_W'(POOL_SLOTS);

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_OPT   = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERSIZE  = 2'd1,
    ST_NO_POOL   = 2'd2,
    ST_BAD_HANDLE= 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LINK,
    S_OPT_CLASS,
    S_OPT_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] request_bytes;
    logic [9:0]  cell_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] granted_handle;
    logic [8:0] cell_bytes;
    logic [4:0] pools_released;
  } out_item_t;

  // cell_link memory access from the sequencer; links carry the empty marker
  typedef struct packed {
    logic                wr_en;
    logic [HANDLE_W-1:0] wr_addr;
    logic [CELL_W-1:0]   wr_data;
    logic [HANDLE_W-1:0] rd_addr;
  } link_req_t;

endpackage

@@ hw/rtl/scpa_ram.sv @@
// ----------------------------------------------------------------------------
// scpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ hw/rtl/size_class_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// size_class_pool_allocator_core
// Size-class cell allocator with per-class free stacks and a spare pool stack.
// ----------------------------------------------------------------------------
// sequence: a non-oversize alloc goes from accept through decode, cell_link read
//   and update to result valid; free and other requests go through decode only;
//   optimize visits every class and walks each pool that it releases
// throughput: one transaction at a time; ready again once the result is taken
// reset: synchronous active-low; all classes empty, all pool slots spare,
//   the cell_link ram is not cleared (every entry is written before read)
module size_class_pool_allocator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  scpa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scpa_pkg::out_item_t out_data
);
  import scpa_pkg::*;

  state_t state_r, state_nxt;
  in_item_t  req_r;
  out_item_t res_r, res_nxt;

  logic [CELL_W-1:0]    free_top_r   [CLASS_COUNT];
  logic [CELL_W-1:0]    fresh_r      [CLASS_COUNT];
  logic [CNT_W-1:0]     used_r       [CLASS_COUNT];
  logic [POOLREF_W-1:0] head_r       [CLASS_COUNT];
  logic [POOLREF_W-1:0] chain_r      [POOL_SLOTS];
  logic [CLS_W-1:0]     owner_r      [POOL_SLOTS];
  logic [SLOT_W-1:0]    spare_r      [POOL_SLOTS];
  logic [POOLREF_W-1:0] spare_cnt_r;
  logic [POOL_SLOTS-1:0] live_r;

  logic [CLS_W-1:0]     cls_r;
  logic [POOLREF_W-1:0] walk_r;
  logic [POOLREF_W-1:0] steps_r;
  logic [4:0]           released_r;

  link_req_t            link_req;
  logic [CELL_W-1:0]    link_rd;

  scpa_ram #(.WIDTH(CELL_W), .DEPTH(TOTAL_CELLS)) u_link (
    .clk    (clk),
    .wr_en  (link_req.wr_en),
    .wr_addr(link_req.wr_addr),
    .wr_data(link_req.wr_data),
    .rd_addr(link_req.rd_addr),
    .rd_data(link_rd)
  );

  // size decode: raise, add header, round to group
  logic [16:0] sz;
  logic [16:0] rnd;
  logic [12:0] cls_full;
  always_comb begin
    sz = (req_r.request_bytes < 16'(MIN_PAYLOAD_BYTES)) ? 17'(MIN_PAYLOAD_BYTES)
                                                         : {1'b0, req_r.request_bytes};
    sz = sz + 17'(HEADER_BYTES) + 17'(GROUP_BYTES - 1);
    rnd = sz & ~17'(GROUP_BYTES - 1);
    cls_full = 13'((sz >> $clog2(GROUP_BYTES)) - 17'd1);
  end

  logic oversize;
  logic [CLS_W-1:0] dcls;
  assign oversize = cls_full >= 13'(CLASS_COUNT);
  assign dcls     = cls_full[CLS_W-1:0];

  logic [SLOT_W-1:0] fslot;
  assign fslot = req_r.cell_handle[HANDLE_W-1 -: SLOT_W];

  logic [8:0] cls_bytes_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = res_r;

  // link ram: read free top at decode, write on free
  always_comb begin
    link_req.wr_en   = 1'b0;
    link_req.wr_addr = req_r.cell_handle;
    link_req.wr_data = free_top_r[owner_r[fslot]];
    link_req.rd_addr = free_top_r[dcls][HANDLE_W-1:0];
    if (state_r == S_DECODE && req_type_t'(req_r.req_type) == REQ_FREE &&
        live_r[fslot]) begin
      link_req.wr_en = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (req_type_t'(req_r.req_type))
          REQ_ALLOC: state_nxt = oversize ? S_DONE : S_LINK;
          REQ_OPT:   state_nxt = S_OPT_CLASS;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_LINK:      state_nxt = S_DONE;
      S_OPT_CLASS: begin
        if (used_r[cls_r] == '0 && head_r[cls_r] < POOL_NONE) state_nxt = S_OPT_WALK;
        else if (cls_r == CLS_W'(CLASS_COUNT - 1)) state_nxt = S_DONE;
      end
      S_OPT_WALK: begin
        if ((chain_r[walk_r[SLOT_W-1:0]] >= POOL_NONE ||
             steps_r == POOLREF_W'(POOL_SLOTS - 1)) &&
            cls_r == CLS_W'(CLASS_COUNT - 1))
          state_nxt = S_DONE;
        else if (chain_r[walk_r[SLOT_W-1:0]] >= POOL_NONE ||
                 steps_r == POOLREF_W'(POOL_SLOTS - 1))
          state_nxt = S_OPT_CLASS;
      end
      S_DONE:      if (out_ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    res_nxt = res_r;
    unique case (state_r)
      S_DECODE: begin
        res_nxt = '0;
        unique case (req_type_t'(req_r.req_type))
          REQ_ALLOC: if (oversize) res_nxt.status = ST_OVERSIZE;
          REQ_FREE: begin
            if (!live_r[fslot]) res_nxt.status = ST_BAD_HANDLE;
            else res_nxt.cell_bytes = 9'((32'(owner_r[fslot]) + 1) * GROUP_BYTES);
          end
          default: ;
        endcase
      end
      S_LINK: begin
        res_nxt.cell_bytes = cls_bytes_r;
        if (free_top_r[cls_r] < CELL_NONE)
          res_nxt.granted_handle = free_top_r[cls_r][HANDLE_W-1:0];
        else if (fresh_r[cls_r] < CELL_NONE)
          res_nxt.granted_handle = fresh_r[cls_r][HANDLE_W-1:0];
        else if (spare_cnt_r == '0)
          res_nxt.status = ST_NO_POOL;
        else
          res_nxt.granted_handle =
            {spare_r[SLOT_W'(spare_cnt_r - 1'b1)], OFS_W'(0)};
      end
      S_OPT_CLASS, S_OPT_WALK: res_nxt.pools_released = released_r;
      default: ;
    endcase
    if (state_r == S_OPT_WALK) res_nxt.pools_released = released_r + 5'd1;
  end

  logic [SLOT_W-1:0] ns;
  assign ns = spare_r[SLOT_W'(spare_cnt_r - 1'b1)];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      spare_cnt_r <= POOLREF_W'(POOL_SLOTS);
      live_r      <= '0;
      for (int i = 0; i < CLASS_COUNT; i++) begin
        free_top_r[i] <= CELL_NONE;
        fresh_r[i]    <= CELL_NONE;
        used_r[i]     <= '0;
        head_r[i]     <= POOL_NONE;
      end
      for (int i = 0; i < POOL_SLOTS; i++) begin
        spare_r[i] <= SLOT_W'(POOL_SLOTS - 1 - i);
      end
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      if (state_r == S_IDLE && in_valid) req_r <= in_data;
      unique case (state_r)
        S_DECODE: begin
          cls_r       <= (req_type_t'(req_r.req_type) == REQ_OPT) ? '0 : dcls;
          cls_bytes_r <= rnd[8:0];
          released_r  <= '0;
          if (req_type_t'(req_r.req_type) == REQ_FREE && live_r[fslot]) begin
            free_top_r[owner_r[fslot]] <= {1'b0, req_r.cell_handle};
            if (used_r[owner_r[fslot]] != '0)
              used_r[owner_r[fslot]] <= used_r[owner_r[fslot]] - 1'b1;
          end
        end
        S_LINK: begin
          if (free_top_r[cls_r] < CELL_NONE) begin
            free_top_r[cls_r] <= link_rd;
            used_r[cls_r]     <= used_r[cls_r] + 1'b1;
          end else if (fresh_r[cls_r] < CELL_NONE) begin
            fresh_r[cls_r] <= (fresh_r[cls_r][OFS_W-1:0] == '1) ? CELL_NONE
                                                                 : fresh_r[cls_r] + 1'b1;
            used_r[cls_r]  <= used_r[cls_r] + 1'b1;
          end else if (spare_cnt_r != '0) begin
            spare_cnt_r   <= spare_cnt_r - 1'b1;
            live_r[ns]    <= 1'b1;
            owner_r[ns]   <= cls_r;
            chain_r[ns]   <= head_r[cls_r];
            head_r[cls_r] <= {1'b0, ns};
            fresh_r[cls_r] <= {1'b0, ns, OFS_W'(1)};
            used_r[cls_r]  <= used_r[cls_r] + 1'b1;
          end
        end
        S_OPT_CLASS: begin
          walk_r  <= head_r[cls_r];
          steps_r <= '0;
          if (used_r[cls_r] == '0) begin
            head_r[cls_r]     <= POOL_NONE;
            free_top_r[cls_r] <= CELL_NONE;
            fresh_r[cls_r]    <= CELL_NONE;
          end
          if (!(used_r[cls_r] == '0 && head_r[cls_r] < POOL_NONE))
            cls_r <= cls_r + 1'b1;
        end
        S_OPT_WALK: begin
          live_r[walk_r[SLOT_W-1:0]] <= 1'b0;
          if (spare_cnt_r < POOLREF_W'(POOL_SLOTS)) begin
            spare_r[spare_cnt_r[SLOT_W-1:0]] <= walk_r[SLOT_W-1:0];
            spare_cnt_r <= spare_cnt_r + 1'b1;
          end
          released_r <= released_r + 5'd1;
          walk_r     <= chain_r[walk_r[SLOT_W-1:0]];
          steps_r    <= steps_r + 1'b1;
          if (chain_r[walk_r[SLOT_W-1:0]] >= POOL_NONE ||
              steps_r == POOLREF_W'(POOL_SLOTS - 1))
            cls_r <= cls_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_spare_range: assert property (@(posedge clk) disable iff (!rst_n)
    spare_cnt_r <= POOLREF_W'(POOL_SLOTS))
    else $error("spare count overflow");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("ready while result pending");

endmodule

@@ tb/size_class_pool_allocator_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_pool_allocator_checker
// Watches both channels of the allocator, keeps its own copy of the class
// lists and pool heap, predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  scpa_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  scpa_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_count,
  output int                  rsp_count,
  output int                  released_total
);
  import scpa_pkg::*;

  logic [CELL_W-1:0]    link_mem [TOTAL_CELLS];
  logic [CELL_W-1:0]    free_top [CLASS_COUNT];
  logic [CELL_W-1:0]    fresh_next [CLASS_COUNT];
  int                   used_cnt [CLASS_COUNT];
  logic [POOLREF_W-1:0] pool_head [CLASS_COUNT];
  logic [POOLREF_W-1:0] chain [POOL_SLOTS];
  int                   owner [POOL_SLOTS];
  int                   spare [POOL_SLOTS];
  int                   spare_cnt;
  bit                   live [POOL_SLOTS];
  out_item_t            rsp_queue [$];

  task automatic clear_heap();
    for (int i = 0; i < CLASS_COUNT; i++) begin
      free_top[i] = CELL_NONE;
      fresh_next[i] = CELL_NONE;
      used_cnt[i] = 0;
      pool_head[i] = POOL_NONE;
    end
    for (int i = 0; i < POOL_SLOTS; i++) begin
      spare[i] = POOL_SLOTS - 1 - i;
      live[i] = 0;
      chain[i] = POOL_NONE;
      owner[i] = 0;
    end
    spare_cnt = POOL_SLOTS;
  endtask

  function automatic out_item_t predict_response(in_item_t req);
    out_item_t r;
    int sz, cb, cls, h, slot, p, nxt, rel;
    r = '0;
    case (req_type_t'(req.req_type))
      REQ_ALLOC: begin
        sz = (req.request_bytes < MIN_PAYLOAD_BYTES) ? MIN_PAYLOAD_BYTES : req.request_bytes;
        sz += HEADER_BYTES;
        cb = ((sz + GROUP_BYTES - 1) / GROUP_BYTES) * GROUP_BYTES;
        cls = cb / GROUP_BYTES - 1;
        if (cls >= CLASS_COUNT) begin
          r.status = ST_OVERSIZE;
          return r;
        end
        if (free_top[cls] < TOTAL_CELLS) begin
          h = free_top[cls];
          free_top[cls] = link_mem[h];
        end else if (fresh_next[cls] < TOTAL_CELLS) begin
          h = fresh_next[cls];
          fresh_next[cls] = ((h + 1) % CELLS_PER_POOL == 0) ? CELL_NONE : CELL_W'(h + 1);
        end else begin
          if (spare_cnt == 0) begin
            r.status = ST_NO_POOL;
            r.cell_bytes = 9'(cb);
            return r;
          end
          spare_cnt--;
          slot = spare[spare_cnt];
          live[slot] = 1;
          owner[slot] = cls;
          chain[slot] = pool_head[cls];
          pool_head[cls] = POOLREF_W'(slot);
          h = slot * CELLS_PER_POOL;
          fresh_next[cls] = CELL_W'(h + 1);
        end
        used_cnt[cls]++;
        r.status = ST_OK;
        r.granted_handle = HANDLE_W'(h);
        r.cell_bytes = 9'(cb);
      end
      REQ_FREE: begin
        h = req.cell_handle;
        slot = h / CELLS_PER_POOL;
        if (h >= TOTAL_CELLS || !live[slot]) begin
          r.status = ST_BAD_HANDLE;
          return r;
        end
        cls = owner[slot];
        link_mem[h] = free_top[cls];
        free_top[cls] = CELL_W'(h);
        if (used_cnt[cls] > 0) used_cnt[cls]--;
        r.cell_bytes = 9'((cls + 1) * GROUP_BYTES);
      end
      REQ_OPT: begin
        rel = 0;
        for (int c = 0; c < CLASS_COUNT; c++) begin
          if (used_cnt[c] != 0) continue;
          p = pool_head[c];
          for (int s = 0; p < POOL_SLOTS && s < POOL_SLOTS; s++) begin
            nxt = chain[p];
            live[p] = 0;
            if (spare_cnt < POOL_SLOTS) spare[spare_cnt++] = p;
            rel++;
            p = nxt;
          end
          pool_head[c] = POOL_NONE;
          free_top[c] = CELL_NONE;
          fresh_next[c] = CELL_NONE;
        end
        r.pools_released = 5'(rel);
        released_total += rel;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_count = rsp_queue.size();

  always @(posedge clk) begin
    out_item_t exp_rsp;
    if (!rst_n) begin
      clear_heap();
      rsp_queue.delete();
      fail_count <= 0;
      rsp_count <= 0;
      released_total = 0;
    end else begin
      if (out_valid && out_ready) begin
        rsp_count <= rsp_count + 1;
        if (rsp_queue.size() == 0) begin
          $display("%0t: unexpected response, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_rsp = rsp_queue.pop_front();
          if (exp_rsp.status !== out_data.status ||
              exp_rsp.granted_handle !== out_data.granted_handle ||
              exp_rsp.cell_bytes !== out_data.cell_bytes ||
              exp_rsp.pools_released !== out_data.pools_released) begin
            $display("%0t: mismatch, expected %p actual %p", $time, exp_rsp, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) rsp_queue.push_back(predict_response(in_data));
    end
  end
endmodule

@@ tb/size_class_pool_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_pool_allocator_core_tb
// Drives alloc, free, optimize and no-op transactions with random gaps and
// backpressure; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module size_class_pool_allocator_core_tb;
  import scpa_pkg::*;

  localparam int RANDOM_ITEMS = 730;
  localparam int IDLE_LIMIT   = 20000;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;
  int        fail_count, pending_count, rsp_count, released_total;
  int        idle_cycles = 0;
  int        sent = 0;
  int        live_handles [$];

  always #5 clk = ~clk;

  size_class_pool_allocator_core dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  size_class_pool_allocator_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data,
    .fail_count, .pending_count, .rsp_count, .released_total
  );

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver stalls; remember granted handles so frees mostly hit live cells
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready && out_data.status == ST_OK && out_data.granted_handle != 0)
        live_handles.push_back(out_data.granted_handle);
      out_ready <= ($urandom_range(0, 99) < 70) || (($time / 4000) % 3 == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays up after an accept until the next gap or drain drops it
  task automatic send(logic [1:0] kind, logic [15:0] bytes, logic [9:0] handle);
    int g;
    g = (($time / 4000) % 3 == 1) ? 0 : gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_data <= '{req_type: kind, request_bytes: bytes, cell_handle: handle};
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] small_bytes();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) return 16'($urandom_range(0, 56));
    if (k < 95) return 16'($urandom_range(0, 248));
    return 16'($urandom_range(0, 16'hffff));
  endfunction

  task automatic random_request();
    int k, idx;
    logic [9:0] h;
    k = $urandom_range(0, 99);
    if (k < 50) send(REQ_ALLOC, small_bytes(), 10'($urandom));
    else if (k < 85 && live_handles.size() > 0) begin
      idx = $urandom_range(0, live_handles.size() - 1);
      h = 10'(live_handles[idx]);
      live_handles.delete(idx);
      send(REQ_FREE, 16'($urandom), h);
    end else if (k < 92) send(REQ_FREE, 16'($urandom), 10'($urandom));
    else if (k < 97) begin
      send(REQ_OPT, 16'($urandom), 10'($urandom));
      live_handles.delete();
    end else send(REQ_NOP, 16'($urandom), 10'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: boundaries, every request kind, error cases
    send(REQ_ALLOC, 16'd0, 10'd0);
    send(REQ_ALLOC, 16'd8, 10'h3ff);
    send(REQ_ALLOC, 16'd9, 10'd0);
    send(REQ_ALLOC, 16'd248, 10'd0);
    send(REQ_ALLOC, 16'd249, 10'd0);
    send(REQ_ALLOC, 16'hffff, 10'h3ff);
    send(REQ_FREE, 16'hffff, 10'd1);
    send(REQ_FREE, 16'd0, 10'd1);
    send(REQ_FREE, 16'd0, 10'h3ff);
    send(REQ_ALLOC, 16'd0, 10'd0);
    send(REQ_OPT, 16'd0, 10'd0);
    send(REQ_FREE, 16'd0, 10'd0);
    send(REQ_FREE, 16'd0, 10'd64);
    send(REQ_FREE, 16'd0, 10'd64);
    send(REQ_OPT, 16'hffff, 10'h3ff);
    send(REQ_NOP, 16'hffff, 10'h3ff);
    // exhaust all spare pools; the last request of the loop is oversize
    for (int c = 0; c < 17; c++) send(REQ_ALLOC, 16'(c * 16), 10'd0);
    send(REQ_OPT, 16'd0, 10'd0);
    live_handles.delete();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        // drain before continuing
        drain();
      end
      random_request();
    end
    drain();
    repeat (60) @(posedge clk);
    $display("covered %0d requests and %0d responses", sent, rsp_count);
    $display("optimize returned %0d pools in total", released_total);
    if (fail_count == 0 && pending_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
